// ----- src/stfp_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and helpers for the stuffed telemetry frame parser.
// Shared by the parser core and the top level; no dependencies.
package stfp_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(FRAME_BYTES);

    localparam logic [7:0] ESC_BYTE = 8'h7D;
    localparam logic [7:0] ESC_CODE_MARK = 8'h5E;
    localparam logic [7:0] ESC_CODE_ESC = 8'h5D;
    localparam logic [7:0] MARK_BYTE = 8'h7E;
    localparam logic [7:0] CSUM_BASE = 8'hFF;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(STORE_DEPTH);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_START_MARKER = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  source_id;
        logic [7:0]  frame_seq;
        logic [15:0] data_id;
        logic [31:0] payload_value;
    } result_t;

    typedef struct packed {
        logic last_due;
    } core_status_t;

    function automatic logic [7:0] unstuff(input logic [7:0] b);
        logic [7:0] r;
        begin
            r = b;
            if (b == ESC_CODE_MARK)
            begin
                r = MARK_BYTE;
            end
            else if (b == ESC_CODE_ESC)
            begin
                r = ESC_BYTE;
            end
            return r;
        end
    endfunction

endpackage

// ----- src/stfp_core.sv -----
`timescale 1ns / 1ps
// Frame state machine, unstuffing, checksum and frame byte store.
// Depends on stfp_pkg.
module stfp_core
    import stfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         beat,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   start_marker,
    output result_t      result,
    output core_status_t status
);

    phase_t           phase_reg, phase_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       store_reg [STORE_DEPTH];

    logic       marker_hit;
    logic       esc_hit;
    logic [7:0] data_byte;
    logic [8:0] sum_wide;
    logic       take;
    logic       wr_en;
    logic       good;

    assign marker_hit = (rx_byte == start_marker);
    assign esc_hit    = (rx_byte == ESC_BYTE);
    assign data_byte  = esc_reg ? unstuff(rx_byte) : rx_byte;
    assign sum_wide   = {1'b0, sum_reg} + {1'b0, data_byte};
    assign take       = ((phase_reg == PH_START) && !marker_hit && !esc_hit)
                     || ((phase_reg == PH_DATA) && !(esc_hit && !esc_reg));

    always_comb
    begin
        phase_next = phase_reg;
        if (beat)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (marker_hit)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_START, PH_DATA:
                begin
                    if (take)
                    begin
                        phase_next = (count_reg == LAST_COUNT) ? PH_IDLE : PH_DATA;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        esc_next   = esc_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        good       = 1'b0;
        if (beat)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (marker_hit)
                    begin
                        esc_next   = 1'b0;
                        count_next = '0;
                        sum_next   = '0;
                    end
                end
                PH_START:
                begin
                    if (marker_hit)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                    end
                    else if (esc_hit)
                    begin
                        esc_next = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    if (esc_hit && !esc_reg)
                    begin
                        esc_next = 1'b1;
                    end
                end
                default:
                begin
                    esc_next = 1'b0;
                end
            endcase
            if (take)
            begin
                esc_next = 1'b0;
                if (count_reg != LAST_COUNT)
                begin
                    sum_next   = sum_wide[7:0] + {7'd0, sum_wide[8]};
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                end
                else
                begin
                    count_next = '0;
                    good       = ((CSUM_BASE - sum_reg) == data_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            esc_reg   <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    assign result.valid         = good;
    assign result.source_id     = store_reg[0];
    assign result.frame_seq     = store_reg[1];
    assign result.data_id       = {store_reg[3], store_reg[2]};
    assign result.payload_value = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};

    assign status.last_due = (phase_reg == PH_DATA) && (count_reg == LAST_COUNT);

endmodule

// ----- src/stuffed_telemetry_frame_parser.sv -----
`timescale 1ns / 1ps
// Top level: stream ports, APB register and result register.
// Depends on stfp_pkg and stfp_core.

// Takes one received byte per cycle on the slave stream and emits one 64-bit
// beat per good frame on the master stream, in the cycle after the frame's
// checksum byte is taken. Byte rate is one beat per clock; the input stalls
// only while the checksum byte of a frame is due and the previous result
// still sits unread in the output register. Bad frames produce nothing. The
// start marker (reset 0x7E) sits at APB address 0 and should be changed only
// while the stream is idle.
module stuffed_telemetry_frame_parser
    import stfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [7:0] source_id, [15:8] frame_seq,
                                             // [31:16] data_id, [63:32] payload_value

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [7:0]   marker_reg;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_data_reg;
    logic         beat;
    logic         reg_sel;
    result_t      result;
    core_status_t status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_IDX_START_MARKER);
    assign prdata  = reg_sel ? {{(APB_DATA_W-8){1'b0}}, marker_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARK_BYTE;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            marker_reg <= pwdata[7:0];
        end
    end

    // hold the input only when a result is due with the output still occupied
    assign s_tready = !(status.last_due && out_valid_reg && !m_tready);
    assign beat     = s_tvalid && s_tready;

    stfp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .rx_byte      (s_tdata),
        .start_marker (marker_reg),
        .result       (result),
        .status       (status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_data_reg <= {result.payload_value, result.data_id,
                             result.frame_seq, result.source_id};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- src/stfp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the stuffed telemetry frame parser and their bind.
// Depends on stfp_pkg and stuffed_telemetry_frame_parser.
module stfp_checker
    import stfp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [63:0]           m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic                  pready,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result beat without a preceding input beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with output free");

    a_marker_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == REG_IDX_START_MARKER))
        |=> (paddr[APB_ADDR_W-1] != REG_IDX_START_MARKER
             || prdata[7:0] == $past(pwdata[7:0])))
        else $error("start marker readback mismatch");

endmodule

bind stuffed_telemetry_frame_parser stfp_checker u_stfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for stuffed_telemetry_frame_parser: byte stream in, one
// decoded telemetry beat out per good frame, start marker set over APB.
// Depends on stfp_pkg and the parser RTL only.
module tb;
    import stfp_pkg::*;

    typedef struct packed {
        logic [31:0] payload_value;
        logic [15:0] data_id;
        logic [7:0]  frame_seq;
        logic [7:0]  source_id;
    } telemetry_t;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENT_ITEMS = 160;
    localparam logic [APB_ADDR_W-1:0] MARKER_ADDR = APB_ADDR_W'(4 * REG_IDX_START_MARKER);
    localparam logic [111:0] OPENING_SEQ = {MARK_BYTE, MARK_BYTE, ESC_BYTE, ESC_BYTE,
        ESC_CODE_MARK, 8'h11, ESC_BYTE, ESC_BYTE, MARK_BYTE, 8'h22, 8'h33, 8'h44,
        ESC_BYTE, 8'h55};
    localparam logic [63:0] OPENING_BODY = 64'h5544_3322_7E7D_117E;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [7:0] rx_pending [$];
    telemetry_t frames_due [$];
    logic       rx_taken = 1'b0;
    int         send_gap_pct = 0;
    int         recv_gap_pct = 0;
    int         hold_requests = 0;
    int         holds_granted = 0;
    int         hold_left = 0;
    int         cycle_count = 0;
    int         mismatches = 0;

    // parser state as the bench sees it
    logic [7:0]  rx_marker = MARK_BYTE;
    phase_t      rx_phase = PH_IDLE;
    logic        rx_escape = 1'b0;
    int          rx_count = 0;
    logic [7:0]  rx_sum = '0;
    logic [63:0] rx_frame = '0;

    stuffed_telemetry_frame_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] carry_add(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] wide;
        begin
            wide = {1'b0, acc} + {1'b0, b};
            return wide[7:0] + {7'b0, wide[8]};
        end
    endfunction

    function automatic logic [7:0] frame_checksum(input logic [63:0] flat);
        logic [7:0] acc;
        int i;
        begin
            acc = '0;
            for (i = 0; i < STORE_DEPTH; i++)
            begin
                acc = carry_add(acc, flat[8*i +: 8]);
            end
            return 8'(CSUM_BASE - acc);
        end
    endfunction

    task automatic take_data_byte(input logic [7:0] raw);
        logic [7:0] b;
        begin
            b = raw;
            if (rx_escape)
            begin
                if (raw == ESC_CODE_MARK)
                begin
                    b = MARK_BYTE;
                end
                else if (raw == ESC_CODE_ESC)
                begin
                    b = ESC_BYTE;
                end
                rx_escape = 1'b0;
            end
            if (rx_count < STORE_DEPTH)
            begin
                rx_sum = carry_add(rx_sum, b);
                rx_frame[8*rx_count +: 8] = b;
                rx_count++;
            end
            else
            begin
                rx_phase = PH_IDLE;
                rx_count = 0;
                if (8'(CSUM_BASE - rx_sum) == b)
                begin
                    frames_due.push_back(telemetry_t'(rx_frame));
                end
            end
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        begin
            case (rx_phase)
                PH_START:
                begin
                    if (b == rx_marker)
                    begin
                        rx_count = 0;
                        rx_sum = '0;
                    end
                    else if (b == ESC_BYTE)
                    begin
                        rx_escape = 1'b1;
                    end
                    else
                    begin
                        rx_phase = PH_DATA;
                        take_data_byte(b);
                    end
                end
                PH_DATA:
                begin
                    if (b == ESC_BYTE && !rx_escape)
                    begin
                        rx_escape = 1'b1;
                    end
                    else
                    begin
                        take_data_byte(b);
                    end
                end
                default:
                begin
                    if (b == rx_marker)
                    begin
                        rx_phase = PH_START;
                        rx_escape = 1'b0;
                        rx_count = 0;
                        rx_sum = '0;
                    end
                end
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        begin
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        end
    endtask

    function automatic logic [7:0] pick_byte();
        begin
            case ($urandom_range(9))
                0: return 8'h00;
                1: return 8'hFF;
                2: return ESC_BYTE;
                3: return MARK_BYTE;
                4: return rx_marker;
                default: return 8'($urandom);
            endcase
        end
    endfunction

    task automatic queue_stuffed(input logic [7:0] b);
        begin
            if (b == ESC_BYTE)
            begin
                rx_pending.push_back(ESC_BYTE);
                rx_pending.push_back(ESC_CODE_ESC);
            end
            else if (b == MARK_BYTE && $urandom_range(1) == 0)
            begin
                rx_pending.push_back(ESC_BYTE);
                rx_pending.push_back(ESC_CODE_MARK);
            end
            else if (b != ESC_CODE_MARK && b != ESC_CODE_ESC && $urandom_range(15) == 0)
            begin
                rx_pending.push_back(ESC_BYTE);
                rx_pending.push_back(b);
            end
            else
            begin
                rx_pending.push_back(b);
            end
        end
    endtask

    task automatic queue_frame(input logic [63:0] body, input bit bad_sum);
        logic [63:0] flat;
        logic [7:0]  sum_byte;
        int          i;
        begin
            flat = body;
            // keep the first byte from reading as a restart or an escape
            while (flat[7:0] == rx_marker || flat[7:0] == ESC_BYTE)
            begin
                flat[7:0] = flat[7:0] + 8'd1;
            end
            sum_byte = frame_checksum(flat);
            if (bad_sum)
            begin
                sum_byte = sum_byte ^ (8'd1 << $urandom_range(7));
            end
            rx_pending.push_back(rx_marker);
            if ($urandom_range(7) == 0)
            begin
                rx_pending.push_back(rx_marker);
            end
            if (rx_marker != ESC_BYTE && flat[7:0] != ESC_CODE_MARK
                && flat[7:0] != ESC_CODE_ESC && $urandom_range(7) == 0)
            begin
                rx_pending.push_back(ESC_BYTE);
            end
            rx_pending.push_back(flat[7:0]);
            for (i = 1; i < STORE_DEPTH; i++)
            begin
                queue_stuffed(flat[8*i +: 8]);
            end
            queue_stuffed(sum_byte);
        end
    endtask

    task automatic queue_traffic(input int n_items);
        int target;
        int pick;
        int n;
        int i;
        begin
            target = rx_pending.size() + n_items;
            while (rx_pending.size() < target)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    queue_frame({pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                                 pick_byte(), pick_byte(), pick_byte(), pick_byte()}, 1'b0);
                end
                else if (pick < 87)
                begin
                    queue_frame({$urandom, $urandom}, 1'b1);
                end
                else
                begin
                    // truncated frame or line noise
                    n = $urandom_range(8);
                    if ($urandom_range(1) == 0)
                    begin
                        rx_pending.push_back(rx_marker);
                    end
                    for (i = 0; i < n; i++)
                    begin
                        rx_pending.push_back(pick_byte());
                    end
                end
            end
        end
    endtask

    task automatic wait_idle();
        begin
            do
                @(posedge clk);
            while (rx_pending.size() != 0 || s_tvalid || frames_due.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_start_marker(input logic [7:0] value);
        begin
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= MARKER_ADDR;
            pwdata <= APB_DATA_W'(value);
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            rx_marker = value;
            @(negedge clk);
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            compare_field("start_marker", APB_DATA_W'(value), prdata);
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // sample both streams; retire result beats before predicting new ones
    always @(posedge clk)
    begin
        telemetry_t want;
        telemetry_t got;
        rx_taken = s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (frames_due.size() == 0)
            begin
                $error("result beat with no frame pending: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                compare_field("source_id", 32'(want.source_id), 32'(got.source_id));
                compare_field("frame_seq", 32'(want.frame_seq), 32'(got.frame_seq));
                compare_field("data_id", 32'(want.data_id), 32'(got.data_id));
                compare_field("payload_value", want.payload_value, got.payload_value);
            end
        end
        if (rx_taken)
        begin
            parse_rx_byte(s_tdata);
        end
    end

    always @(negedge clk)
    begin
        if (!s_tvalid || rx_taken)
        begin
            if (rst_n && rx_pending.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_pending.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_granted != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            holds_granted++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int i;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 17;
        recv_gap_pct = 60;
        // restart, escapes before data, marker and double escape inside data
        for (i = 13; i >= 0; i--)
        begin
            rx_pending.push_back(OPENING_SEQ[8*i +: 8]);
        end
        queue_stuffed(frame_checksum(OPENING_BODY));
        queue_frame({64{1'b1}}, 1'b0);
        queue_frame('0, 1'b1);
        wait_idle();

        // marker equal to the escape byte
        write_start_marker(ESC_BYTE);
        rx_pending.push_back(ESC_BYTE);
        queue_traffic(SEGMENT_ITEMS);
        wait_idle();

        send_gap_pct = 60;
        recv_gap_pct = 17;
        write_start_marker(8'h00);
        queue_traffic(SEGMENT_ITEMS);
        wait_idle();
        write_start_marker(8'hFF);
        queue_traffic(SEGMENT_ITEMS);
        wait_idle();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_start_marker(8'($urandom_range(255)));
        hold_requests++;
        queue_traffic(SEGMENT_ITEMS);
        wait_idle();
        write_start_marker(MARK_BYTE);
        queue_traffic(SEGMENT_ITEMS);
        wait_idle();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
